// File: src/sfv_pkg.sv
`timescale 1ns / 1ps

package sfv_pkg;

    localparam int FRAME_BYTES_DEF = 56;
    localparam int NUM_FIELDS      = 15;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [15:0] MIN_STEPS   = 16'd1;
    localparam logic [15:0] MAX_STEPS   = 16'd256;
    localparam logic [15:0] MAX_CHANNEL = 16'd78;
    localparam logic [15:0] MAX_QUALITY = 16'd1000;
    localparam logic [15:0] MAX_TUNC    = 16'd10000;

    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_QUAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLAGS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_LIM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RTT_LIM   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_LIM  = 3'd7;

    localparam logic [4:0] ST_OK        = 5'd0;
    localparam logic [4:0] ST_LENGTH    = 5'd1;
    localparam logic [4:0] ST_MAGIC     = 5'd2;
    localparam logic [4:0] ST_VERSION   = 5'd3;
    localparam logic [4:0] ST_FLAGS     = 5'd4;
    localparam logic [4:0] ST_CRC       = 5'd5;
    localparam logic [4:0] ST_SOURCE    = 5'd6;
    localparam logic [4:0] ST_SESSION   = 5'd7;
    localparam logic [4:0] ST_PROCEDURE = 5'd8;
    localparam logic [4:0] ST_STEP      = 5'd9;
    localparam logic [4:0] ST_CHANNEL   = 5'd10;
    localparam logic [4:0] ST_QUALITY   = 5'd11;
    localparam logic [4:0] ST_PHASE     = 5'd12;
    localparam logic [4:0] ST_RTT       = 5'd13;
    localparam logic [4:0] ST_FREQ      = 5'd14;
    localparam logic [4:0] ST_TIMING    = 5'd15;
    localparam logic [4:0] ST_STALE     = 5'd16;

    typedef struct packed {
        logic [31:0] max_age;
        logic [9:0]  min_quality;
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  allowed_flags;
        logic [30:0] phase_limit;
        logic [30:0] rtt_limit;
        logic [30:0] freq_limit;
    } t_cfg;

    typedef logic signed [32:0] t_value;

    // One byte of the reflected CRC-32, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: src/sounding_frame_validator.sv
`timescale 1ns / 1ps

// Frame validator for fixed-size channel-sounding measurement frames.
// The input channel (i_valid, o_ready) carries one frame byte per item, and
// i_frame_end marks the last byte of a frame. One byte is taken per cycle
// while o_ready is high; the CRC-32 update of each byte before the CRC word
// is done in the cycle it is accepted. After the last byte, the buffered
// frame is checked in one pass and the outcome is loaded into the output
// stage once that stage is free. The output channel (o_valid, i_ready) then
// gives either one item carrying an error status, or a run of 15 items with
// the decoded fields, o_run_last on the final one. A frame passes the check
// stage, then the output stage; one result leaves per cycle while the
// receiver takes them. A well-formed frame has FRAME_BYTES bytes, so a
// full run of 15 results never slows a well-formed stream. When the
// receiver stalls, a checked frame waits in the output stage and one
// finished frame waits in front of it; input is held off only while both are full.
// A synchronous reset clears the byte count, the CRC, both stages and loads
// the register defaults; the frame buffer itself is not cleared.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data.
module sounding_frame_validator
    import sfv_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_frame_end,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [4:0]             o_status,
    output logic [3:0]             o_field_index,
    output logic signed [32:0]     o_field_value,
    output logic                   o_run_last
);

    localparam int CNT_W = $clog2(FRAME_BYTES + 2);
    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_CRC  = CNT_W'(FRAME_BYTES - 4);
    localparam logic [3:0] LAST_FIELD = 4'(NUM_FIELDS - 1);

    t_cfg            r_cfg;
    logic [7:0]      r_store [FRAME_BYTES];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]     r_crc, n_crc;
    logic [CNT_W-1:0] r_len;
    logic [31:0]     r_crc_fin;
    logic            r_chk_valid;
    logic            r_busy;
    logic [4:0]      r_status;
    logic [3:0]      r_idx;
    t_value          r_vals [NUM_FIELDS];

    logic [4:0]      chk_status;
    t_value          chk_vals [NUM_FIELDS];
    logic            in_fire, out_fire, emit_last, emit_free, move;

    sfv_check #(.FRAME_BYTES(FRAME_BYTES)) u_check (
        .i_store  (r_store),
        .i_len    (r_len),
        .i_crc    (r_crc_fin),
        .i_cfg    (r_cfg),
        .o_status (chk_status),
        .o_vals   (chk_vals)
    );

    assign emit_last = (r_status != ST_OK) || (r_idx == LAST_FIELD);
    assign out_fire  = r_busy && i_ready;
    assign emit_free = !r_busy || (out_fire && emit_last);
    assign move      = r_chk_valid && emit_free;
    assign o_ready   = !r_chk_valid || emit_free;
    assign in_fire   = i_valid && o_ready;

    assign n_crc = (r_cnt < CNT_CRC) ? crc_byte(r_crc, i_data_byte) : r_crc;
    assign n_cnt = (r_cnt <= CNT_FULL) ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_age       <= 32'hffff_ffff;
            r_cfg.min_quality   <= 10'd0;
            r_cfg.magic         <= 32'd0;
            r_cfg.version       <= 8'd1;
            r_cfg.allowed_flags <= 8'd0;
            r_cfg.phase_limit   <= 31'd3142;
            r_cfg.rtt_limit     <= 31'h7fff_ffff;
            r_cfg.freq_limit    <= 31'h7fff_ffff;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_AGE:   r_cfg.max_age       <= i_cfg_data;
                REG_MIN_QUAL:  r_cfg.min_quality   <= i_cfg_data[9:0];
                REG_MAGIC:     r_cfg.magic         <= i_cfg_data;
                REG_VERSION:   r_cfg.version       <= i_cfg_data[7:0];
                REG_FLAGS:     r_cfg.allowed_flags <= i_cfg_data[7:0];
                REG_PHASE_LIM: r_cfg.phase_limit   <= i_cfg_data[30:0];
                REG_RTT_LIM:   r_cfg.rtt_limit     <= i_cfg_data[30:0];
                REG_FREQ_LIM:  r_cfg.freq_limit    <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && r_cnt < CNT_FULL) begin
            r_store[r_cnt[IDX_W-1:0]] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_crc       <= CRC_INIT;
            r_chk_valid <= 1'b0;
        end else begin
            if (move) begin
                r_chk_valid <= 1'b0;
            end
            if (in_fire) begin
                if (i_frame_end) begin
                    r_len       <= n_cnt;
                    r_crc_fin   <= n_crc;
                    r_cnt       <= '0;
                    r_crc       <= CRC_INIT;
                    r_chk_valid <= 1'b1;
                end else begin
                    r_cnt <= n_cnt;
                    r_crc <= n_crc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (move) begin
            r_busy   <= 1'b1;
            r_status <= chk_status;
            r_idx    <= '0;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_vals[k] <= (chk_status == ST_OK) ? chk_vals[k] : '0;
            end
        end else if (out_fire) begin
            if (emit_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
                for (int k = 0; k < NUM_FIELDS - 1; k++) begin
                    r_vals[k] <= r_vals[k+1];
                end
            end
        end
    end

    assign o_valid       = r_busy;
    assign o_status      = r_status;
    assign o_field_index = r_idx;
    assign o_field_value = r_vals[0];
    assign o_run_last    = emit_last;

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_run_last && o_field_index == 4'd0)
        else $error("error result is not a single item");

    a_end_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_frame_end |=> r_chk_valid && r_cnt == '0)
        else $error("frame end did not hand the frame to the check");

    a_run_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !emit_last |=> o_valid && o_field_index == $past(o_field_index) + 4'd1)
        else $error("field run did not advance");

endmodule

// File: src/sfv_check.sv
`timescale 1ns / 1ps

module sfv_check
    import sfv_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic [7:0]                     i_store [FRAME_BYTES],
    input  logic [$clog2(FRAME_BYTES+2)-1:0] i_len,
    input  logic [31:0]                    i_crc,
    input  t_cfg                           i_cfg,
    output logic [4:0]                     o_status,
    output t_value                         o_vals [NUM_FIELDS]
);

    localparam logic [$clog2(FRAME_BYTES+2)-1:0] LEN_EXP =
        ($clog2(FRAME_BYTES+2))'(FRAME_BYTES);
    localparam logic [15:0] DECL_EXP = 16'(FRAME_BYTES);

    logic [31:0] magic, seq, age, src, ph, rtt, fo, ses, proc, crc_word;
    logic [15:0] chan, qual, tunc, sidx, scnt, decl_len;
    logic signed [32:0] ph_s, fo_s, ph_lim, fo_lim;

    assign magic    = {i_store[3], i_store[2], i_store[1], i_store[0]};
    assign decl_len = {i_store[9], i_store[8]};
    assign chan     = {i_store[11], i_store[10]};
    assign seq      = {i_store[15], i_store[14], i_store[13], i_store[12]};
    assign age      = {i_store[19], i_store[18], i_store[17], i_store[16]};
    assign src      = {i_store[23], i_store[22], i_store[21], i_store[20]};
    assign qual     = {i_store[25], i_store[24]};
    assign tunc     = {i_store[27], i_store[26]};
    assign ph       = {i_store[31], i_store[30], i_store[29], i_store[28]};
    assign rtt      = {i_store[35], i_store[34], i_store[33], i_store[32]};
    assign fo       = {i_store[39], i_store[38], i_store[37], i_store[36]};
    assign ses      = {i_store[43], i_store[42], i_store[41], i_store[40]};
    assign proc     = {i_store[47], i_store[46], i_store[45], i_store[44]};
    assign sidx     = {i_store[49], i_store[48]};
    assign scnt     = {i_store[51], i_store[50]};
    assign crc_word = {i_store[FRAME_BYTES-1], i_store[FRAME_BYTES-2],
                       i_store[FRAME_BYTES-3], i_store[FRAME_BYTES-4]};

    assign ph_s   = $signed({ph[31], ph});
    assign fo_s   = $signed({fo[31], fo});
    assign ph_lim = $signed({2'b00, i_cfg.phase_limit});
    assign fo_lim = $signed({2'b00, i_cfg.freq_limit});

    always_comb begin
        if (i_len != LEN_EXP) begin
            o_status = ST_LENGTH;
        end else if (magic != i_cfg.magic) begin
            o_status = ST_MAGIC;
        end else if (i_store[4] != i_cfg.version) begin
            o_status = ST_VERSION;
        end else if (i_store[7] != 8'd0 || decl_len != DECL_EXP) begin
            o_status = ST_LENGTH;
        end else if ((i_store[5] & ~i_cfg.allowed_flags) != 8'd0) begin
            o_status = ST_FLAGS;
        end else if ((i_crc ^ CRC_INIT) != crc_word) begin
            o_status = ST_CRC;
        end else if (src == 32'd0) begin
            o_status = ST_SOURCE;
        end else if (ses == 32'd0) begin
            o_status = ST_SESSION;
        end else if (proc == 32'd0) begin
            o_status = ST_PROCEDURE;
        end else if (scnt < MIN_STEPS || scnt > MAX_STEPS || sidx >= scnt) begin
            o_status = ST_STEP;
        end else if (chan > MAX_CHANNEL) begin
            o_status = ST_CHANNEL;
        end else if (qual < {6'd0, i_cfg.min_quality} || qual > MAX_QUALITY) begin
            o_status = ST_QUALITY;
        end else if (ph_s > ph_lim || ph_s < -ph_lim) begin
            o_status = ST_PHASE;
        end else if (rtt[31] || rtt[30:0] > i_cfg.rtt_limit) begin
            o_status = ST_RTT;
        end else if (fo_s > fo_lim || fo_s < -fo_lim) begin
            o_status = ST_FREQ;
        end else if (tunc > MAX_TUNC) begin
            o_status = ST_TIMING;
        end else if (age > i_cfg.max_age) begin
            o_status = ST_STALE;
        end else begin
            o_status = ST_OK;
        end
    end

    assign o_vals[0]  = $signed({25'd0, i_store[5]});
    assign o_vals[1]  = $signed({25'd0, i_store[6]});
    assign o_vals[2]  = $signed({17'd0, chan});
    assign o_vals[3]  = $signed({1'b0, seq});
    assign o_vals[4]  = $signed({1'b0, age});
    assign o_vals[5]  = $signed({1'b0, src});
    assign o_vals[6]  = $signed({17'd0, qual});
    assign o_vals[7]  = $signed({17'd0, tunc});
    assign o_vals[8]  = ph_s;
    assign o_vals[9]  = $signed({rtt[31], rtt});
    assign o_vals[10] = fo_s;
    assign o_vals[11] = $signed({1'b0, ses});
    assign o_vals[12] = $signed({1'b0, proc});
    assign o_vals[13] = $signed({17'd0, sidx});
    assign o_vals[14] = $signed({17'd0, scnt});

endmodule

// File: tb/tb_sounding_frame_validator.sv
`timescale 1ns / 1ps

module tb_sounding_frame_validator;
    import sfv_pkg::*;

    localparam int FB        = 56;
    localparam int CYC_LIMIT = 400000;

    typedef enum int {
        K_GOOD, K_MAGIC, K_VERSION, K_DECLEN, K_BYTE7, K_FLAGS, K_CRC, K_SRC, K_SES,
        K_PROC, K_STEP, K_CHAN, K_QUAL, K_PHASE, K_RTT, K_FREQ, K_TUNC, K_AGE,
        K_SHORT, K_LONG, K_NOISE, K_COUNT
    } t_kind;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
    } t_byte_item;

    typedef struct packed {
        logic [4:0]  st;
        logic [3:0]  idx;
        logic [32:0] val;
        logic        last;
    } t_field_item;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic drv_valid = 1'b0;
    logic [7:0] drv_byte = 8'd0;
    logic drv_end = 1'b0;
    logic rdy = 1'b0;
    logic o_ready, o_valid, o_run_last;
    logic [4:0] o_status;
    logic [3:0] o_field_index;
    logic signed [32:0] o_field_value;

    t_byte_item  pending_bytes[$];
    t_field_item expected_fields[$];
    int errors = 0;
    int cyc = 0;

    // Frame predictor state and register copies.
    logic [7:0]  fs_store[0:FB-1];
    int          fs_count;
    logic [31:0] fs_crc;
    logic [31:0] r_age;
    logic [9:0]  r_minq;
    logic [31:0] r_magic;
    logic [7:0]  r_ver;
    logic [7:0]  r_flags;
    logic [30:0] r_ph, r_rtt, r_fo;

    logic [7:0] fb[0:63];
    int flen;

    sounding_frame_validator uut (
        .i_clk(i_clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(drv_valid), .o_ready(o_ready),
        .i_data_byte(drv_byte), .i_frame_end(drv_end),
        .o_valid(o_valid), .i_ready(rdy),
        .o_status(o_status), .o_field_index(o_field_index),
        .o_field_value(o_field_value), .o_run_last(o_run_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = (r >> 1) ^ ({32{r[0]}} & 32'hedb88320);
        return r;
    endfunction

    function automatic logic [31:0] st32(int at);
        return {fs_store[at+3], fs_store[at+2], fs_store[at+1], fs_store[at]};
    endfunction

    function automatic logic [31:0] st16(int at);
        return {16'd0, fs_store[at+1], fs_store[at]};
    endfunction

    task automatic predict_frame_byte(logic [7:0] b, logic fin);
        longint vals[15];
        logic [4:0] st;
        longint ph, rtt, fo;
        logic [31:0] src, ses, prc, sidx, scnt, chan, qual, tunc, age;
        t_field_item fi;
        if (fs_count < FB) begin
            fs_store[fs_count] = b;
            if (fs_count < FB - 4) fs_crc = crc_step(fs_crc, b);
        end
        if (fs_count <= FB) fs_count++;
        if (!fin) return;
        st = ST_OK;
        chan = st16(10); age = st32(16); src = st32(20); qual = st16(24); tunc = st16(26);
        ph = $signed(st32(28)); rtt = $signed(st32(32)); fo = $signed(st32(36));
        ses = st32(40); prc = st32(44); sidx = st16(48); scnt = st16(50);
        vals = '{fs_store[5], fs_store[6], chan, st32(12), age, src, qual, tunc,
                 ph, rtt, fo, ses, prc, sidx, scnt};
        if (fs_count != FB) st = ST_LENGTH;
        else if (st32(0) != r_magic) st = ST_MAGIC;
        else if (fs_store[4] != r_ver) st = ST_VERSION;
        else if (fs_store[7] != 8'd0 || st16(8) != FB) st = ST_LENGTH;
        else if ((fs_store[5] & ~r_flags) != 8'd0) st = ST_FLAGS;
        else if ((fs_crc ^ 32'hffffffff) != st32(FB - 4)) st = ST_CRC;
        else if (src == 0) st = ST_SOURCE;
        else if (ses == 0) st = ST_SESSION;
        else if (prc == 0) st = ST_PROCEDURE;
        else if (scnt < 1 || scnt > 256 || sidx >= scnt) st = ST_STEP;
        else if (chan > 78) st = ST_CHANNEL;
        else if (qual < r_minq || qual > 1000) st = ST_QUALITY;
        else if (ph < -longint'(r_ph) || ph > longint'(r_ph)) st = ST_PHASE;
        else if (rtt < 0 || rtt > longint'(r_rtt)) st = ST_RTT;
        else if (fo < -longint'(r_fo) || fo > longint'(r_fo)) st = ST_FREQ;
        else if (tunc > 10000) st = ST_TIMING;
        else if (age > r_age) st = ST_STALE;
        fs_count = 0;
        fs_crc = 32'hffffffff;
        if (st != ST_OK) begin
            fi = '{st, 4'd0, 33'd0, 1'b1};
            expected_fields.push_back(fi);
        end else begin
            for (int i = 0; i < 15; i++) begin
                fi = '{ST_OK, 4'(i), vals[i][32:0], i == 14};
                expected_fields.push_back(fi);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        case (idx)
            REG_MAX_AGE:   r_age = d;
            REG_MIN_QUAL:  r_minq = d[9:0];
            REG_MAGIC:     r_magic = d;
            REG_VERSION:   r_ver = d[7:0];
            REG_FLAGS:     r_flags = d[7:0];
            REG_PHASE_LIM: r_ph = d[30:0];
            REG_RTT_LIM:   r_rtt = d[30:0];
            REG_FREQ_LIM:  r_fo = d[30:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= d;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] age, logic [31:0] minq, logic [31:0] magic,
                             logic [31:0] ver, logic [31:0] flg, logic [31:0] ph,
                             logic [31:0] rtt, logic [31:0] fo);
        write_reg(REG_MAX_AGE, age);
        write_reg(REG_MIN_QUAL, minq);
        write_reg(REG_MAGIC, magic);
        write_reg(REG_VERSION, ver);
        write_reg(REG_FLAGS, flg);
        write_reg(REG_PHASE_LIM, ph);
        write_reg(REG_RTT_LIM, rtt);
        write_reg(REG_FREQ_LIM, fo);
    endtask

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic void put16(int at, logic [31:0] v);
        fb[at] = v[7:0];
        fb[at+1] = v[15:8];
    endfunction

    function automatic void put32(int at, logic [31:0] v);
        put16(at, v);
        put16(at + 2, v >> 16);
    endfunction

    task automatic queue_frame(t_kind kind);
        logic [31:0] scnt, v, c;
        t_byte_item it;
        put32(0, r_magic);
        fb[4] = r_ver;
        fb[5] = $urandom & r_flags;
        fb[6] = $urandom;
        fb[7] = 8'd0;
        put16(8, FB);
        put16(10, pick(0, 78));
        put32(12, $urandom);
        put32(16, pick(0, r_age));
        put32(20, pick(1, 32'hffffffff));
        put16(24, pick((r_minq > 1000) ? 1000 : r_minq, 1000));
        put16(26, pick(0, 10000));
        put32(28, pick(0, {r_ph, 1'b0}) - r_ph);
        put32(32, pick(0, r_rtt));
        put32(36, pick(0, {r_fo, 1'b0}) - r_fo);
        put32(40, pick(1, 32'hffffffff));
        put32(44, pick(1, 32'hffffffff));
        scnt = pick(1, 256);
        put16(50, scnt);
        put16(48, pick(0, scnt - 1));
        case (kind)
            K_MAGIC:   fb[$urandom_range(0, 3)] ^= 8'd1 << $urandom_range(0, 7);
            K_VERSION: fb[4] ^= 8'($urandom_range(1, 255));
            K_DECLEN:  fb[8 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            K_BYTE7:   fb[7] = $urandom_range(1, 255);
            K_FLAGS:   fb[5] |= ~r_flags;
            K_SRC:     put32(20, 0);
            K_SES:     put32(40, 0);
            K_PROC:    put32(44, 0);
            K_STEP: begin
                case ($urandom_range(0, 2))
                    0: put16(50, 0);
                    1: put16(50, $urandom_range(257, 65535));
                    default: put16(48, $urandom_range(scnt, 65535));
                endcase
            end
            K_CHAN: put16(10, $urandom_range(79, 65535));
            K_QUAL: begin
                if (r_minq > 0 && $urandom_range(0, 1)) put16(24, $urandom_range(0, r_minq - 1));
                else put16(24, $urandom_range(1001, 65535));
            end
            K_PHASE: begin
                v = r_ph + 1;
                put32(28, $urandom_range(0, 1) ? v : -v);
            end
            K_RTT: put32(32, $urandom_range(0, 1) ? (r_rtt + 32'd1) : ($urandom | 32'h80000000));
            K_FREQ: begin
                v = r_fo + 1;
                put32(36, $urandom_range(0, 1) ? v : -v);
            end
            K_TUNC: put16(26, $urandom_range(10001, 65535));
            K_AGE: if (r_age != 32'hffffffff) put32(16, $urandom_range(r_age + 1, 32'hffffffff));
            default: ;
        endcase
        c = 32'hffffffff;
        for (int i = 0; i < FB - 4; i++) c = crc_step(c, fb[i]);
        put32(FB - 4, ~c);
        if (kind == K_CRC) fb[$urandom_range(0, FB - 1)] ^= 8'd1 << $urandom_range(0, 7);
        flen = FB;
        if (kind == K_SHORT) flen = $urandom_range(1, FB - 1);
        if (kind == K_LONG) begin
            flen = $urandom_range(FB + 1, 64);
            for (int i = FB; i < flen; i++) fb[i] = $urandom;
        end
        if (kind == K_NOISE) begin
            flen = $urandom_range(1, 64);
            for (int i = 0; i < flen; i++) fb[i] = $urandom;
        end
        for (int i = 0; i < flen; i++) begin
            it.b = fb[i];
            it.e = (i == flen - 1) || (kind == K_NOISE && $urandom_range(0, 15) == 0);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic queue_random_frames(int n);
        repeat (n) begin
            if ($urandom_range(0, 1)) queue_frame(K_GOOD);
            else queue_frame(t_kind'($urandom_range(1, K_COUNT - 1)));
        end
    endtask

    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_bytes.size() != 0 || drv_valid || expected_fields.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    // Sender: bursts of items separated by random gaps.
    int gap_left = 0;
    int burst_left = 0;
    logic slot_busy;
    t_byte_item next_item;
    always @(posedge i_clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            slot_busy = drv_valid;
            if (drv_valid && o_ready) begin
                predict_frame_byte(drv_byte, drv_end);
                slot_busy = 1'b0;
            end
            if (!slot_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    drv_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    next_item = pending_bytes.pop_front();
                    drv_byte <= next_item.b;
                    drv_end <= next_item.e;
                    drv_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern drawn from one of four modes, redrawn periodically.
    int rx_mode = 0;
    always @(posedge i_clk) begin
        if (cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: rdy <= 1'b1;
            1: rdy <= $urandom_range(0, 1);
            2: rdy <= ($urandom_range(0, 3) == 0);
            default: rdy <= (cyc % 5 != 0);
        endcase
    end

    t_field_item want;
    always @(posedge i_clk) begin
        if (rst_n && o_valid && rdy) begin
            if (expected_fields.size() == 0) begin
                errors++;
                $display("%0t: unexpected item status=%0d idx=%0d value=%0d last=%0b",
                         $time, o_status, o_field_index, o_field_value, o_run_last);
            end else begin
                want = expected_fields.pop_front();
                if (o_status !== want.st) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, o_status);
                end
                if (o_field_index !== want.idx) begin
                    errors++;
                    $display("%0t: field_index expected %0d actual %0d",
                             $time, want.idx, o_field_index);
                end
                if (o_field_value !== want.val) begin
                    errors++;
                    $display("%0t: field_value expected %h actual %h",
                             $time, want.val, o_field_value);
                end
                if (o_run_last !== want.last) begin
                    errors++;
                    $display("%0t: run_last expected %0b actual %0b",
                             $time, want.last, o_run_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < FB; i++) fs_store[i] = 8'd0;
        fs_count = 0;
        fs_crc = 32'hffffffff;
        r_age = 32'hffffffff; r_minq = 10'd0; r_magic = 32'd0; r_ver = 8'd1;
        r_flags = 8'd0; r_ph = 31'd3142; r_rtt = 31'h7fffffff; r_fo = 31'h7fffffff;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed: a good frame, a one-byte frame, one failing frame and a second good frame.
        queue_frame(K_GOOD);
        pending_bytes.push_back('{8'hA5, 1'b1});
        queue_frame(t_kind'($urandom_range(1, K_COUNT - 1)));
        queue_frame(K_GOOD);
        drain();

        write_all($urandom, $urandom_range(0, 1000), $urandom, $urandom, $urandom,
                  $urandom_range(0, 32'h7fffffff), $urandom_range(0, 32'h7fffffff),
                  $urandom_range(0, 32'h7fffffff));
        queue_random_frames(2);
        drain();

        write_all(0, 1000, 32'hffffffff, 8'hff, 8'hff, 0, 0, 0);
        queue_random_frames(1);
        drain();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
